// ----- rtl/lfucr_pkg.sv -----
// Package for the LFU cache replacement directory.
// Holds table geometry, field widths and the derived index widths.
// No dependencies.
package lfucr_pkg;

	// Table geometry and entry field widths.
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 48;
	localparam int COUNT_BITS = 16;
	localparam int STAMP_BITS = 32;

	// Port widths fixed by the interface.
	localparam int PAGE_KEY_BITS = 48;
	localparam int CAP_BITS      = 5;
	localparam int TOTAL_BITS    = 32;

	// Derived widths.
	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS = $clog2(ENTRIES + 1);

	// Capacity after reset.
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [OCC_BITS-1:0]   occ_t;
	typedef logic [TOTAL_BITS-1:0] total_t;

endpackage

// ----- rtl/lfu_cache_replacement_core.sv -----
// LFU cache replacement directory, top level.
// Fully associative table scanned one entry per cycle by a shared compare unit.
// Depends on lfucr_pkg.
// Input channel: in_valid, page_key, is_write; the block drives in_stall.
// A transaction completes at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid and the result fields; the receiver drives
// out_stall. A result transaction completes with out_valid high and out_stall
// low. The result fields hold while the receiver stalls.
// Configuration: cfg_valid, cfg_data (capacity_in_use); cfg_ready is always
// high. Write it only while the block is idle.
// An accepted access is scanned one entry per cycle (one key, count and stamp
// age compare each), then an update cycle writes the table and loads the result
// and raises out_valid; only then does the block return to idle and take the
// next access. An access may be taken while a result still waits; its update
// then holds until that result is taken.
// arst_n clears all valid bits, occupancy, the stamp counter and the running
// totals, and sets the capacity to 16. The block is ready right after reset.
module lfu_cache_replacement_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Access channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lfucr_pkg::PAGE_KEY_BITS-1:0] page_key,
	input  logic                           is_write,
	// Configuration channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lfucr_pkg::CAP_BITS-1:0] cfg_data,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic                           victim_valid,
	output logic [lfucr_pkg::PAGE_KEY_BITS-1:0] victim_key,
	output logic                           victim_dirty,
	output logic [lfucr_pkg::TOTAL_BITS-1:0] access_count,
	output logic [lfucr_pkg::TOTAL_BITS-1:0] hit_count,
	output logic [lfucr_pkg::TOTAL_BITS-1:0] read_hit_count,
	output logic [lfucr_pkg::TOTAL_BITS-1:0] write_hit_count,
	output logic [lfucr_pkg::TOTAL_BITS-1:0] dirty_eviction_count
);
	import lfucr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

	state_t state_q;

	// Table storage.
	logic [ENTRIES-1:0] valid_q;
	key_t               entry_key_q   [ENTRIES];
	count_t             entry_count_q [ENTRIES];
	stamp_t             entry_stamp_q [ENTRIES];
	logic               entry_dirty_q [ENTRIES];

	// Directory state and totals.
	occ_t          occupancy_q;
	stamp_t        stamp_q;
	logic [CAP_BITS-1:0] cap_q;
	total_t        access_total_q;
	total_t        hit_total_q;
	total_t        read_hit_total_q;
	total_t        write_hit_total_q;
	total_t        dirty_evict_total_q;

	// Current access.
	key_t key_q;
	logic wr_q;

	// Scan tracking.
	idx_t   scan_idx_q;
	logic   found_q;
	idx_t   found_idx_q;
	logic   best_valid_q;
	idx_t   best_idx_q;
	count_t best_count_q;
	stamp_t best_age_q;
	logic   free_valid_q;
	idx_t   free_idx_q;

	// Result payload.
	logic         hit_q;
	logic         victim_valid_q;
	logic [PAGE_KEY_BITS-1:0] victim_key_q;
	logic         victim_dirty_q;

	// Scan compare unit signals.
	logic   cur_valid;
	count_t cur_count;
	stamp_t cur_age;
	logic   cur_match;
	logic   take_found;
	logic   take_best;
	logic   take_free;

	// Update signals.
	logic [OCC_BITS-1:0] cap_eff;
	logic   evict;
	idx_t   slot;
	logic   out_free;
	logic   in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// Compare unit: looks at one entry per scan cycle.
	always_comb begin
		cur_valid  = valid_q[scan_idx_q];
		cur_count  = entry_count_q[scan_idx_q];
		cur_age    = stamp_q - entry_stamp_q[scan_idx_q];
		cur_match  = cur_valid && (entry_key_q[scan_idx_q] == key_q);
		take_found = cur_match && !found_q;
		take_best  = cur_valid && (!best_valid_q || (cur_count < best_count_q) ||
			((cur_count == best_count_q) && (cur_age > best_age_q)));
		take_free  = !cur_valid && !free_valid_q;
	end

	// Effective capacity: zero acts as one, large values clamp to the table size.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = OCC_BITS'(1);
		end else if (32'(cap_q) > 32'(ENTRIES)) begin
			cap_eff = OCC_BITS'(ENTRIES);
		end else begin
			cap_eff = OCC_BITS'(cap_q);
		end
		evict = (occupancy_q >= cap_eff) && best_valid_q;
		slot  = evict ? best_idx_q : free_idx_q;
	end

	// Control state, valid bits, counters and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			valid_q             <= '0;
			occupancy_q         <= '0;
			stamp_q             <= '0;
			cap_q               <= CAP_RESET;
			access_total_q      <= '0;
			hit_total_q         <= '0;
			read_hit_total_q    <= '0;
			write_hit_total_q   <= '0;
			dirty_evict_total_q <= '0;
			scan_idx_q          <= '0;
			found_q             <= 1'b0;
			best_valid_q        <= 1'b0;
			free_valid_q        <= 1'b0;
			out_valid           <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			// The update cycle loads a new result itself.
			if (out_valid && !out_stall && (state_q != ST_UPDATE)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						scan_idx_q   <= '0;
						found_q      <= 1'b0;
						best_valid_q <= 1'b0;
						free_valid_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (take_found) begin
						found_q <= 1'b1;
					end
					if (take_best) begin
						best_valid_q <= 1'b1;
					end
					if (take_free) begin
						free_valid_q <= 1'b1;
					end
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_idx_q <= scan_idx_q + idx_t'(1);
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						access_total_q <= access_total_q + total_t'(1);
						stamp_q        <= stamp_q + stamp_t'(1);
						if (found_q) begin
							hit_total_q <= hit_total_q + total_t'(1);
							if (wr_q) begin
								write_hit_total_q <= write_hit_total_q + total_t'(1);
							end else begin
								read_hit_total_q <= read_hit_total_q + total_t'(1);
							end
						end else begin
							valid_q[slot] <= 1'b1;
							if (evict) begin
								if (entry_dirty_q[best_idx_q]) begin
									dirty_evict_total_q <= dirty_evict_total_q + total_t'(1);
								end
							end else begin
								occupancy_q <= occupancy_q + occ_t'(1);
							end
						end
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: access, scan results, table fields and result fields.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= key_t'(page_key);
			wr_q  <= is_write;
		end
		if (state_q == ST_SCAN) begin
			if (take_found) begin
				found_idx_q <= scan_idx_q;
			end
			if (take_best) begin
				best_idx_q   <= scan_idx_q;
				best_count_q <= cur_count;
				best_age_q   <= cur_age;
			end
			if (take_free) begin
				free_idx_q <= scan_idx_q;
			end
		end
		if ((state_q == ST_UPDATE) && out_free) begin
			hit_q <= found_q;
			if (found_q) begin
				if (entry_count_q[found_idx_q] != '1) begin
					entry_count_q[found_idx_q] <= entry_count_q[found_idx_q] + count_t'(1);
				end
				entry_stamp_q[found_idx_q] <= stamp_q;
				if (wr_q) begin
					entry_dirty_q[found_idx_q] <= 1'b1;
				end
				victim_valid_q <= 1'b0;
				victim_key_q   <= '0;
				victim_dirty_q <= 1'b0;
			end else begin
				entry_key_q[slot]   <= key_q;
				entry_count_q[slot] <= count_t'(1);
				entry_stamp_q[slot] <= stamp_q;
				entry_dirty_q[slot] <= wr_q;
				victim_valid_q      <= evict;
				if (evict) begin
					victim_key_q   <= PAGE_KEY_BITS'(entry_key_q[best_idx_q]);
					victim_dirty_q <= entry_dirty_q[best_idx_q];
				end else begin
					victim_key_q   <= '0;
					victim_dirty_q <= 1'b0;
				end
			end
		end
	end

	// Result fields.
	assign hit                  = hit_q;
	assign victim_valid         = victim_valid_q;
	assign victim_key           = victim_key_q;
	assign victim_dirty         = victim_dirty_q;
	assign access_count         = access_total_q;
	assign hit_count            = hit_total_q;
	assign read_hit_count       = read_hit_total_q;
	assign write_hit_count      = write_hit_total_q;
	assign dirty_eviction_count = dirty_evict_total_q;

endmodule

// ----- bench/lfu_cache_replacement_core_tb.sv -----
// Self-checking testbench for the LFU cache replacement directory.
// Drives directed and random accesses, predicts every result and compares.
// Depends on lfucr_pkg and lfu_cache_replacement_core.
`timescale 1ns / 100ps

module lfu_cache_replacement_core_tb;
	import lfucr_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 192;
	localparam int PHASES        = 8;
	localparam int IDLE_PERCENT  = 30;
	localparam int PENDING_DEPTH = 8;
	localparam int MAX_ROWS      = 32;

	// One result transaction as seen on the output ports.
	typedef struct packed {
		logic                     hit;
		logic                     victim_valid;
		logic [PAGE_KEY_BITS-1:0] victim_key;
		logic                     victim_dirty;
		total_t                   accesses;
		total_t                   hits;
		total_t                   read_hits;
		total_t                   write_hits;
		total_t                   dirty_evictions;
	} access_result_t;

	// One row of the directed table; a typed row carries its result inline.
	typedef struct packed {
		logic                     cfg_write;
		logic [CAP_BITS-1:0]      cfg_value;
		logic [PAGE_KEY_BITS-1:0] key;
		logic                     wr;
		logic                     typed;
		access_result_t           want;
	} directed_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [PAGE_KEY_BITS-1:0]  page_key;
	logic                      is_write;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CAP_BITS-1:0]       cfg_data;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      hit;
	logic                      victim_valid;
	logic [PAGE_KEY_BITS-1:0]  victim_key;
	logic                      victim_dirty;
	total_t                    access_count;
	total_t                    hit_count;
	total_t                    read_hit_count;
	total_t                    write_hit_count;
	total_t                    dirty_eviction_count;

	// Shadow copy of the directory table and its counters.
	logic                slot_valid [ENTRIES];
	key_t                slot_key   [ENTRIES];
	count_t              slot_uses  [ENTRIES];
	stamp_t              slot_stamp [ENTRIES];
	logic                slot_dirty [ENTRIES];
	int unsigned         occupied;
	stamp_t              stamp_now;
	total_t              tot_access, tot_hit, tot_read_hit, tot_write_hit, tot_dirty_evict;
	logic [CAP_BITS-1:0] cap_reg;

	// Expected results in order, kept in a small ring.
	access_result_t  pending_results [PENDING_DEPTH];
	int unsigned     pend_head = 0, pend_tail = 0, pend_count = 0;
	directed_row_t   directed_rows [MAX_ROWS];
	int unsigned     row_count = 0;
	logic            steady = 1'b0;
	int unsigned     mismatches, results_seen, quiet_cycles;
	int unsigned     accesses_sent, hits_sent, evictions_sent, dirty_sent, cfg_writes;

	lfu_cache_replacement_core dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.page_key             (page_key),
		.is_write             (is_write),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_data             (cfg_data),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.hit                  (hit),
		.victim_valid         (victim_valid),
		.victim_key           (victim_key),
		.victim_dirty         (victim_dirty),
		.access_count         (access_count),
		.hit_count            (hit_count),
		.read_hit_count       (read_hit_count),
		.write_hit_count      (write_hit_count),
		.dirty_eviction_count (dirty_eviction_count)
	);

	always #4 clk = ~clk;

	// Applies one access to the shadow table and returns the result it must produce.
	function automatic access_result_t predict_access(input logic [PAGE_KEY_BITS-1:0] key_in,
			input logic wr);
		access_result_t r;
		key_t           k;
		int unsigned    eff_cap;
		int             found, best, slot;
		count_t         best_uses;
		stamp_t         best_age, age;
		r = '0;
		k = key_t'(key_in);
		eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
		tot_access++;
		found = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && slot_valid[i] && slot_key[i] == k)
				found = i;
		if (found >= 0) begin
			// Hit: bump the saturating count and restamp the slot.
			r.hit = 1'b1;
			tot_hit++;
			if (slot_uses[found] != '1)
				slot_uses[found]++;
			slot_stamp[found] = stamp_now;
			stamp_now++;
			if (wr) begin
				tot_write_hit++;
				slot_dirty[found] = 1'b1;
			end else begin
				tot_read_hit++;
			end
		end else begin
			// Miss: evict the least used slot, oldest first, when at capacity.
			slot = -1;
			if (occupied >= eff_cap) begin
				best = -1;
				best_uses = '0;
				best_age = '0;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i]) begin
						age = stamp_now - slot_stamp[i];
						if (best < 0 || slot_uses[i] < best_uses ||
								(slot_uses[i] == best_uses && age > best_age)) begin
							best = i;
							best_uses = slot_uses[i];
							best_age = age;
						end
					end
				end
				if (best >= 0) begin
					r.victim_valid = 1'b1;
					r.victim_key = PAGE_KEY_BITS'(slot_key[best]);
					r.victim_dirty = slot_dirty[best];
					if (slot_dirty[best])
						tot_dirty_evict++;
					slot_valid[best] = 1'b0;
					occupied--;
					slot = best;
				end
			end
			if (slot < 0)
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !slot_valid[i])
						slot = i;
			if (slot >= 0) begin
				slot_valid[slot] = 1'b1;
				slot_key[slot] = k;
				slot_uses[slot] = count_t'(1);
				slot_stamp[slot] = stamp_now;
				stamp_now++;
				slot_dirty[slot] = wr;
				occupied++;
			end
		end
		r.accesses = tot_access;
		r.hits = tot_hit;
		r.read_hits = tot_read_hit;
		r.write_hits = tot_write_hit;
		r.dirty_evictions = tot_dirty_evict;
		return r;
	endfunction

	function automatic access_result_t result_of(input logic h, input logic vv,
			input logic [PAGE_KEY_BITS-1:0] vk, input logic vd, input int unsigned a,
			input int unsigned hc, input int unsigned rh, input int unsigned wh,
			input int unsigned de);
		access_result_t r;
		r = '{hit: h, victim_valid: vv, victim_key: vk, victim_dirty: vd,
			accesses: a, hits: hc, read_hits: rh, write_hits: wh, dirty_evictions: de};
		return r;
	endfunction

	task automatic add_row(input logic cfg_w, input logic [CAP_BITS-1:0] cfg_v,
			input logic [PAGE_KEY_BITS-1:0] k, input logic w, input logic typed,
			input access_result_t want);
		directed_row_t row;
		row = '{cfg_write: cfg_w, cfg_value: cfg_v, key: k, wr: w, typed: typed, want: want};
		directed_rows[row_count] = row;
		row_count++;
	endtask

	// Appends an expected result at the tail of the ring.
	function automatic void queue_result(input access_result_t r);
		if (pend_count == PENDING_DEPTH) begin
			$display("Expected-result ring overflowed");
		end else begin
			pending_results[pend_tail] = r;
			pend_tail = (pend_tail + 1) % PENDING_DEPTH;
			pend_count++;
		end
	endfunction

	// Removes the oldest expected result from the ring.
	function automatic access_result_t take_result();
		access_result_t r;
		r = pending_results[pend_head];
		pend_head = (pend_head + 1) % PENDING_DEPTH;
		pend_count--;
		return r;
	endfunction

	function automatic logic idle_roll();
		return !steady && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	// Sends one access transaction; entered and left just after a falling edge.
	task automatic drive_access(input logic [PAGE_KEY_BITS-1:0] k, input logic w,
			input logic typed, input access_result_t want);
		access_result_t predicted;
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		page_key <= k;
		is_write <= w;
		do @(posedge clk); while (in_stall);
		predicted = predict_access(k, w);
		queue_result(typed ? want : predicted);
		accesses_sent++;
		hits_sent += predicted.hit;
		evictions_sent += predicted.victim_valid;
		dirty_sent += predicted.victim_dirty;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pend_count != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Capacity writes only happen once every outstanding result has been taken.
	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on result %0d, %s: expected %0h, got %0h",
					results_seen, name, want, got);
		end
	endtask

	task automatic check_result();
		access_result_t want;
		results_seen++;
		if (pend_count == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result %0d arrived with nothing outstanding", results_seen);
		end else begin
			want = take_result();
			check_field("hit", want.hit, hit);
			check_field("victim_valid", want.victim_valid, victim_valid);
			check_field("victim_key", want.victim_key, victim_key);
			check_field("victim_dirty", want.victim_dirty, victim_dirty);
			check_field("access_count", want.accesses, access_count);
			check_field("hit_count", want.hits, hit_count);
			check_field("read_hit_count", want.read_hits, read_hit_count);
			check_field("write_hit_count", want.write_hits, write_hit_count);
			check_field("dirty_eviction_count", want.dirty_evictions, dirty_eviction_count);
		end
	endtask

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Result monitor, sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
	end

	// Watchdog: ends the run when no transaction completes for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("No transaction completed for %0d cycles", QUIET_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Main stimulus.
	initial begin
		logic [CAP_BITS-1:0]      phase_caps [PHASES];
		logic [PAGE_KEY_BITS-1:0] key_pool [20];
		logic [PAGE_KEY_BITS-1:0] k;
		int unsigned              pool_size, roll;
		phase_caps = '{5'd16, 5'd4, 5'd1, 5'd16, 5'd8, 5'd0, 5'd31, 5'd2};
		arst_n = 1'b0;
		in_valid = 1'b0;
		page_key = '0;
		is_write = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		accesses_sent = 0;
		hits_sent = 0;
		evictions_sent = 0;
		dirty_sent = 0;
		cfg_writes = 0;
		// Shadow state after reset.
		for (int i = 0; i < ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_uses[i] = '0;
			slot_stamp[i] = '0;
			slot_dirty[i] = 1'b0;
		end
		occupied = 0;
		stamp_now = '0;
		tot_access = '0;
		tot_hit = '0;
		tot_read_hit = '0;
		tot_write_hit = '0;
		tot_dirty_evict = '0;
		cap_reg = CAP_RESET;

		// Directed table: reset state, key extremes, capacity extremes and lowering.
		add_row(1'b0, 5'd0, '0, 1'b0, 1'b1, result_of(1'b0, 1'b0, '0, 1'b0, 1, 0, 0, 0, 0));
		add_row(1'b0, 5'd0, '1, 1'b1, 1'b1, result_of(1'b0, 1'b0, '0, 1'b0, 2, 0, 0, 0, 0));
		add_row(1'b0, 5'd0, '0, 1'b1, 1'b1, result_of(1'b1, 1'b0, '0, 1'b0, 3, 1, 0, 1, 0));
		add_row(1'b0, 5'd0, '1, 1'b0, 1'b1, result_of(1'b1, 1'b0, '0, 1'b0, 4, 2, 1, 1, 0));
		add_row(1'b0, 5'd0, 48'h1, 1'b0, 1'b1,
			result_of(1'b0, 1'b0, '0, 1'b0, 5, 2, 1, 1, 0));
		// Capacity dropped below occupancy: each miss evicts one slot.
		add_row(1'b1, 5'd1, 48'h8000_0000_0000, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h8000_0000_0000, 1'b1, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h2, 1'b1, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h3, 1'b0, 1'b0, '0);
		// A capacity of zero behaves as one.
		add_row(1'b1, 5'd0, 48'h3, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h4, 1'b0, 1'b0, '0);
		// Capacity above the table size behaves as the full table.
		add_row(1'b1, 5'd31, 48'h5, 1'b1, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h6, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h7, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'h5, 1'b0, 1'b0, '0);
		add_row(1'b1, 5'd2, 48'h9, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'hA, 1'b1, 1'b0, '0);
		add_row(1'b1, 5'd16, 48'h5555_5555_5555, 1'b1, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, '0);
		add_row(1'b0, 5'd0, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < row_count; i++) begin
			if (directed_rows[i].cfg_write)
				write_capacity(directed_rows[i].cfg_value);
			drive_access(directed_rows[i].key, directed_rows[i].wr, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random phases: a working set a little larger than the capacity, with a
		// hot subset so counts climb, some near-duplicate keys and some noise.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			steady = (p == 3);
			pool_size = ((phase_caps[p] == 0) ? 1 :
				((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p])) + 3;
			key_pool[0] = PAGE_KEY_BITS'({$urandom(), $urandom()});
			for (int i = 1; i < 20; i++)
				if (i % 2 == 0)
					key_pool[i] = PAGE_KEY_BITS'({$urandom(), $urandom()});
				else
					key_pool[i] = key_pool[0] ^ (PAGE_KEY_BITS'(1) << $urandom_range(47));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (roll < 35)
					k = key_pool[$urandom_range(2)];
				else if (roll < 90)
					k = key_pool[$urandom_range(pool_size - 1)];
				else
					k = PAGE_KEY_BITS'({$urandom(), $urandom()});
				drive_access(k, $urandom_range(99) < 40, 1'b0, '0);
			end
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		wait_drained();
		repeat (ENTRIES + 4) @(posedge clk);

		$display("Run covered %0d accesses with %0d hits and %0d evictions (%0d dirty).",
			accesses_sent, hits_sent, evictions_sent, dirty_sent);
		$display("Capacity was written %0d times, including 0, 1, 16 and 31.", cfg_writes);
		if (mismatches == 0 && pend_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, pend_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
